>>> src/mid_pkg.sv
package mid_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned KindW = 5;
  localparam int unsigned RegW  = 5;

  localparam logic [WordW-1:0] ResetStart = 32'd584;
  localparam logic [WordW-1:0] AddrStep   = 32'd4;

  // mnemonic codes
  localparam logic [KindW-1:0] K_NOP     = 5'd0;
  localparam logic [KindW-1:0] K_SW      = 5'd1;
  localparam logic [KindW-1:0] K_LW      = 5'd2;
  localparam logic [KindW-1:0] K_J       = 5'd3;
  localparam logic [KindW-1:0] K_BEQ     = 5'd4;
  localparam logic [KindW-1:0] K_BNE     = 5'd5;
  localparam logic [KindW-1:0] K_BGTZ    = 5'd6;
  localparam logic [KindW-1:0] K_BLEZ    = 5'd7;
  localparam logic [KindW-1:0] K_BLTZ    = 5'd8;
  localparam logic [KindW-1:0] K_BGEZ    = 5'd9;
  localparam logic [KindW-1:0] K_ADDI    = 5'd10;
  localparam logic [KindW-1:0] K_ADDIU   = 5'd11;
  localparam logic [KindW-1:0] K_SLTI    = 5'd12;
  localparam logic [KindW-1:0] K_BREAK   = 5'd13;
  localparam logic [KindW-1:0] K_SLT     = 5'd14;
  localparam logic [KindW-1:0] K_SLTU    = 5'd15;
  localparam logic [KindW-1:0] K_SLL     = 5'd16;
  localparam logic [KindW-1:0] K_SRL     = 5'd17;
  localparam logic [KindW-1:0] K_SRA     = 5'd18;
  localparam logic [KindW-1:0] K_SUB     = 5'd19;
  localparam logic [KindW-1:0] K_SUBU    = 5'd20;
  localparam logic [KindW-1:0] K_ADD     = 5'd21;
  localparam logic [KindW-1:0] K_ADDU    = 5'd22;
  localparam logic [KindW-1:0] K_AND     = 5'd23;
  localparam logic [KindW-1:0] K_OR      = 5'd24;
  localparam logic [KindW-1:0] K_XOR     = 5'd25;
  localparam logic [KindW-1:0] K_NOR     = 5'd26;
  localparam logic [KindW-1:0] K_DATA    = 5'd27;
  localparam logic [KindW-1:0] K_INVALID = 5'd28;

  // major opcodes
  localparam logic [5:0] OP_SPECIAL = 6'b000000;
  localparam logic [5:0] OP_REGIMM  = 6'b000001;
  localparam logic [5:0] OP_J       = 6'b000010;
  localparam logic [5:0] OP_BEQ     = 6'b000100;
  localparam logic [5:0] OP_BNE     = 6'b000101;
  localparam logic [5:0] OP_BLEZ    = 6'b000110;
  localparam logic [5:0] OP_BGTZ    = 6'b000111;
  localparam logic [5:0] OP_ADDI    = 6'b001000;
  localparam logic [5:0] OP_ADDIU   = 6'b001001;
  localparam logic [5:0] OP_SLTI    = 6'b001010;
  localparam logic [5:0] OP_LW      = 6'b100011;
  localparam logic [5:0] OP_SW      = 6'b101011;

  // special group function codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_BREAK = 6'h0D;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  // regimm rt selectors
  localparam logic [4:0] RI_BLTZ = 5'd0;
  localparam logic [4:0] RI_BGEZ = 5'd1;

  // config register byte address
  localparam int unsigned         CfgAddrW     = 3;
  localparam logic [CfgAddrW-1:0] CfgStartAddr = 3'd0;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic [RegW-1:0]         reg_first;
    logic [RegW-1:0]         reg_second;
    logic [RegW-1:0]         reg_third;
    logic signed [WordW-1:0] value;
  } dec_t;

  // decode-stage handoff to the address/mode tracker
  typedef struct packed {
    logic adv;   // a valid word left the decode stage
    logic brk;   // that word was BREAK
  } step_t;

endpackage

>>> src/mid_if.sv
interface mid_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface mid_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        address;
  logic [4:0]         kind;
  logic [4:0]         reg_first;
  logic [4:0]         reg_second;
  logic [4:0]         reg_third;
  logic signed [31:0] value;

  modport source (output valid, output address, output kind, output reg_first,
                  output reg_second, output reg_third, output value, input ready);
  modport sink   (input valid, input address, input kind, input reg_first,
                  input reg_second, input reg_third, input value, output ready);
endinterface

>>> src/mid_decode.sv
module mid_decode import mid_pkg::*; (
  input  logic [WordW-1:0] word,
  input  logic             data_mode,
  output dec_t             dec
);

  logic [5:0]       op;
  logic [5:0]       fn;
  logic [RegW-1:0]  rs;
  logic [RegW-1:0]  rt;
  logic [RegW-1:0]  rd;
  logic [RegW-1:0]  sa;
  logic [WordW-1:0] imm;
  logic [WordW-1:0] boff;
  logic [KindW-1:0] fn_kind;

  assign op   = word[31:26];
  assign fn   = word[5:0];
  assign rs   = word[25:21];
  assign rt   = word[20:16];
  assign rd   = word[15:11];
  assign sa   = word[10:6];
  assign imm  = {{16{word[15]}}, word[15:0]};
  assign boff = {imm[29:0], 2'b00};

  always_comb begin
    case (fn)
      FN_BREAK: fn_kind = K_BREAK;
      FN_SLT:   fn_kind = K_SLT;
      FN_SLTU:  fn_kind = K_SLTU;
      FN_SLL:   fn_kind = K_SLL;
      FN_SRL:   fn_kind = K_SRL;
      FN_SRA:   fn_kind = K_SRA;
      FN_SUB:   fn_kind = K_SUB;
      FN_SUBU:  fn_kind = K_SUBU;
      FN_ADD:   fn_kind = K_ADD;
      FN_ADDU:  fn_kind = K_ADDU;
      FN_AND:   fn_kind = K_AND;
      FN_OR:    fn_kind = K_OR;
      FN_XOR:   fn_kind = K_XOR;
      FN_NOR:   fn_kind = K_NOR;
      default:  fn_kind = K_INVALID;
    endcase
  end

  always_comb begin
    dec = '0;
    dec.kind = K_INVALID;
    if (data_mode) begin
      dec.kind  = K_DATA;
      dec.value = word;
    end else if (word == '0) begin
      dec.kind = K_NOP;   // all-zero word is NOP, not SLL
    end else begin
      case (op)
        OP_SW, OP_LW, OP_ADDI, OP_ADDIU, OP_SLTI: begin
          case (op)
            OP_SW:    dec.kind = K_SW;
            OP_LW:    dec.kind = K_LW;
            OP_ADDI:  dec.kind = K_ADDI;
            OP_ADDIU: dec.kind = K_ADDIU;
            default:  dec.kind = K_SLTI;
          endcase
          dec.reg_first  = rt;
          dec.reg_second = rs;
          dec.value      = imm;
        end
        OP_J: begin
          dec.kind  = K_J;
          dec.value = {4'b0000, word[25:0], 2'b00};
        end
        OP_BEQ, OP_BNE: begin
          dec.kind       = (op == OP_BEQ) ? K_BEQ : K_BNE;
          dec.reg_first  = rs;
          dec.reg_second = rt;
          dec.value      = boff;
        end
        OP_BGTZ, OP_BLEZ: begin
          dec.kind      = (op == OP_BGTZ) ? K_BGTZ : K_BLEZ;
          dec.reg_first = rs;
          dec.value     = boff;
        end
        OP_REGIMM: begin
          if (rt == RI_BLTZ || rt == RI_BGEZ) begin
            dec.kind      = (rt == RI_BLTZ) ? K_BLTZ : K_BGEZ;
            dec.reg_first = rs;
            dec.value     = boff;
          end
        end
        OP_SPECIAL: begin
          dec.kind = fn_kind;
          if (fn_kind == K_SLL || fn_kind == K_SRL || fn_kind == K_SRA) begin
            dec.reg_first  = rd;
            dec.reg_second = rt;
            dec.value      = {{(WordW-RegW){1'b0}}, sa};
          end else if (fn_kind != K_BREAK && fn_kind != K_INVALID) begin
            dec.reg_first  = rd;
            dec.reg_second = rs;
            dec.reg_third  = rt;
          end
        end
        default: dec.kind = K_INVALID;
      endcase
    end
  end

endmodule

>>> src/mid_state.sv
module mid_state import mid_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [WordW-1:0]    pwdata,
  output logic [WordW-1:0]    prdata,
  input  step_t               step,
  output logic [WordW-1:0]    addr_cnt,
  output logic                data_mode
);

  logic [WordW-1:0] start_r, start_nxt;
  logic [WordW-1:0] cnt_r, cnt_nxt;
  logic             dmode_r, dmode_nxt;
  logic             wr_start;

  assign wr_start = psel && penable && pwrite && (paddr[CfgAddrW-1:2] == CfgStartAddr[CfgAddrW-1:2]);

  always_comb begin
    start_nxt = start_r;
    cnt_nxt   = cnt_r;
    dmode_nxt = dmode_r;
    if (step.adv) begin
      cnt_nxt = cnt_r + AddrStep;
    end
    if (step.brk) begin
      dmode_nxt = 1'b1;
    end
    // writing the start address also reloads the counter
    if (wr_start) begin
      start_nxt = pwdata;
      cnt_nxt   = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= ResetStart;
      cnt_r   <= ResetStart;
      dmode_r <= 1'b0;
    end else begin
      start_r <= start_nxt;
      cnt_r   <= cnt_nxt;
      dmode_r <= dmode_nxt;
    end
  end

  assign prdata    = (paddr[CfgAddrW-1:2] == CfgStartAddr[CfgAddrW-1:2]) ? start_r : '0;
  assign addr_cnt  = cnt_r;
  assign data_mode = dmode_r;

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    step.adv && !wr_start |=> cnt_r == $past(cnt_r) + AddrStep)
    else $error("address counter did not advance by one word");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step.adv && !wr_start |=> cnt_r == $past(cnt_r))
    else $error("address counter moved without a valid word");

  a_mode_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    dmode_r |=> dmode_r)
    else $error("data mode left without reset");

endmodule

>>> src/mips_instruction_decoder_core.sv
// Channel  Dir  Handshake    Payload
// in_ch    in   valid/ready  instruction_word[31:0]
// out_ch   out  valid/ready  address[31:0], kind[4:0], reg_first/second/third[4:0], value[31:0]
// cfg      in   APB          start_address at byte 0 (write reloads the counter)
//
// One request per cycle sustained while out_ch is ready; a result passes through the
// input register, then is decoded into the result register before it is valid.
// rst_n is synchronous: start address and counter return to 584, data mode clears.
// A stalled result holds in the output register; the input register keeps taking
// requests until both stages are full.
module mips_instruction_decoder_core import mid_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  mid_in_if.sink              in_ch,
  mid_out_if.source           out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [WordW-1:0]    pwdata,
  output logic [WordW-1:0]    prdata,
  output logic                pready
);

  logic             s1_v_r, s1_v_nxt;
  logic [WordW-1:0] s1_word_r;
  logic             o_v_r, o_v_nxt;
  logic [WordW-1:0] o_addr_r;
  dec_t             o_dec_r;
  dec_t             dec;
  step_t            step;
  logic             move;
  logic             in_acc;
  logic [WordW-1:0] addr_cnt;
  logic             data_mode;

  assign move        = s1_v_r && (!o_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || move;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign step.adv = move && (dec.kind != K_INVALID);
  assign step.brk = move && (dec.kind == K_BREAK);

  mid_decode u_decode (
    .word      (s1_word_r),
    .data_mode (data_mode),
    .dec       (dec)
  );

  mid_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .step      (step),
    .addr_cnt  (addr_cnt),
    .data_mode (data_mode)
  );

  assign pready = 1'b1;

  always_comb begin
    s1_v_nxt = in_acc || (s1_v_r && !move);
    o_v_nxt  = move || (o_v_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r <= in_ch.instruction_word;
    end
    if (move) begin
      o_addr_r <= addr_cnt;
      o_dec_r  <= dec;
    end
  end

  assign out_ch.valid      = o_v_r;
  assign out_ch.address    = o_addr_r;
  assign out_ch.kind       = o_dec_r.kind;
  assign out_ch.reg_first  = o_dec_r.reg_first;
  assign out_ch.reg_second = o_dec_r.reg_second;
  assign out_ch.reg_third  = o_dec_r.reg_third;
  assign out_ch.value      = o_dec_r.value;

  a_move_lands: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> o_v_r)
    else $error("decoded request lost between stages");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && o_dec_r.kind == K_INVALID |->
      o_dec_r.reg_first == '0 && o_dec_r.reg_second == '0 &&
      o_dec_r.reg_third == '0 && o_dec_r.value == '0)
    else $error("invalid result carries nonzero fields");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && o_v_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while both stages are full");

endmodule

>>> tb/tb_mips_instruction_decoder_core.sv
module tb_mips_instruction_decoder_core;
  import mid_pkg::*;

  localparam int CycleLimit = 300000;

  typedef struct packed {
    logic [WordW-1:0] address;
    dec_t             fields;
  } decode_rec_t;

  // Tracks the decoder's address counter and data mode, and holds the
  // decodes still owed by the block.
  class expected_decodes;
    logic [WordW-1:0] start_addr;
    logic [WordW-1:0] addr_count;
    bit               data_mode;
    decode_rec_t      pending_decodes[$];
    int               errors;

    function new();
      start_addr = ResetStart;
      addr_count = ResetStart;
      data_mode  = 1'b0;
      errors     = 0;
    endfunction

    function void load_start(logic [WordW-1:0] a);
      start_addr = a;
      addr_count = a;
    endfunction

    function int pending();
      return pending_decodes.size();
    endfunction

    function void note_request(logic [WordW-1:0] w);
      decode_rec_t r;
      logic [5:0]  op;
      logic [4:0]  rs, rt, rd, sa;
      logic [31:0] imm, boff;
      op   = w[31:26];
      rs   = w[25:21];
      rt   = w[20:16];
      rd   = w[15:11];
      sa   = w[10:6];
      imm  = {{16{w[15]}}, w[15:0]};
      boff = {imm[29:0], 2'b00};
      r = '0;
      r.address = addr_count;
      r.fields.kind = K_INVALID;
      if (data_mode) begin
        r.fields.kind  = K_DATA;
        r.fields.value = w;
      end else if (w == '0) begin
        r.fields.kind = K_NOP;
      end else begin
        case (op)
          OP_SW, OP_LW, OP_ADDI, OP_ADDIU, OP_SLTI: begin
            case (op)
              OP_SW:   r.fields.kind = K_SW;
              OP_LW:   r.fields.kind = K_LW;
              OP_ADDI: r.fields.kind = K_ADDI;
              OP_ADDIU: r.fields.kind = K_ADDIU;
              default: r.fields.kind = K_SLTI;
            endcase
            r.fields.reg_first  = rt;
            r.fields.reg_second = rs;
            r.fields.value      = imm;
          end
          OP_J: begin
            r.fields.kind  = K_J;
            r.fields.value = {4'b0000, w[25:0], 2'b00};
          end
          OP_BEQ, OP_BNE: begin
            r.fields.kind       = (op == OP_BEQ) ? K_BEQ : K_BNE;
            r.fields.reg_first  = rs;
            r.fields.reg_second = rt;
            r.fields.value      = boff;
          end
          OP_BGTZ, OP_BLEZ: begin
            r.fields.kind      = (op == OP_BGTZ) ? K_BGTZ : K_BLEZ;
            r.fields.reg_first = rs;
            r.fields.value     = boff;
          end
          OP_REGIMM: begin
            if (rt == RI_BLTZ || rt == RI_BGEZ) begin
              r.fields.kind      = (rt == RI_BLTZ) ? K_BLTZ : K_BGEZ;
              r.fields.reg_first = rs;
              r.fields.value     = boff;
            end
          end
          OP_SPECIAL: begin
            case (w[5:0])
              FN_BREAK: r.fields.kind = K_BREAK;
              FN_SLT:   r.fields.kind = K_SLT;
              FN_SLTU:  r.fields.kind = K_SLTU;
              FN_SLL:   r.fields.kind = K_SLL;
              FN_SRL:   r.fields.kind = K_SRL;
              FN_SRA:   r.fields.kind = K_SRA;
              FN_SUB:   r.fields.kind = K_SUB;
              FN_SUBU:  r.fields.kind = K_SUBU;
              FN_ADD:   r.fields.kind = K_ADD;
              FN_ADDU:  r.fields.kind = K_ADDU;
              FN_AND:   r.fields.kind = K_AND;
              FN_OR:    r.fields.kind = K_OR;
              FN_XOR:   r.fields.kind = K_XOR;
              FN_NOR:   r.fields.kind = K_NOR;
              default:  r.fields.kind = K_INVALID;
            endcase
            if (r.fields.kind inside {K_SLL, K_SRL, K_SRA}) begin
              r.fields.reg_first  = rd;
              r.fields.reg_second = rt;
              r.fields.value      = {27'd0, sa};
            end else if (r.fields.kind != K_INVALID && r.fields.kind != K_BREAK) begin
              r.fields.reg_first  = rd;
              r.fields.reg_second = rs;
              r.fields.reg_third  = rt;
            end
          end
          default: ;
        endcase
      end
      if (r.fields.kind != K_INVALID) addr_count = addr_count + AddrStep;
      if (r.fields.kind == K_BREAK) data_mode = 1'b1;
      pending_decodes.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(decode_rec_t got);
      decode_rec_t want;
      if (pending_decodes.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_decodes.pop_front();
        compare_field("address", want.address, got.address);
        compare_field("kind", 32'(want.fields.kind), 32'(got.fields.kind));
        compare_field("reg_first", 32'(want.fields.reg_first),
                      32'(got.fields.reg_first));
        compare_field("reg_second", 32'(want.fields.reg_second),
                      32'(got.fields.reg_second));
        compare_field("reg_third", 32'(want.fields.reg_third),
                      32'(got.fields.reg_third));
        compare_field("value", want.fields.value, got.fields.value);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [WordW-1:0]    pwdata;
  logic [WordW-1:0]    prdata;
  logic                pready;

  mid_in_if  in_ch();
  mid_out_if out_ch();

  mips_instruction_decoder_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  expected_decodes book;
  logic [WordW-1:0] word_q[$];
  int               cycle_count;
  int               stall_mode;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) book.note_request(in_ch.instruction_word);
  end

  always @(posedge clk) begin
    decode_rec_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.address           = out_ch.address;
      got.fields.kind       = out_ch.kind;
      got.fields.reg_first  = out_ch.reg_first;
      got.fields.reg_second = out_ch.reg_second;
      got.fields.reg_third  = out_ch.reg_third;
      got.fields.value      = out_ch.value;
      book.check_result(got);
    end
  end

  // result side back-pressure: steady, random, periodic or long stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 150 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 9) < 6);
      2: out_ch.ready <= (cycle_count % 5 >= 2);
      default: out_ch.ready <= (cycle_count[5:3] != 3'd0);
    endcase
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // mostly well-formed instructions with random fields; BREAK is kept out
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          s;
    int          pick;
    w    = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      s = $urandom_range(0, 24);
      case (s)
        0:  w[31:26] = OP_SW;
        1:  w[31:26] = OP_LW;
        2:  w[31:26] = OP_J;
        3:  w[31:26] = OP_BEQ;
        4:  w[31:26] = OP_BNE;
        5:  w[31:26] = OP_BGTZ;
        6:  w[31:26] = OP_BLEZ;
        7:  w[31:26] = OP_ADDI;
        8:  w[31:26] = OP_ADDIU;
        9:  w[31:26] = OP_SLTI;
        10: w = {OP_REGIMM, w[25:21], RI_BLTZ, w[15:0]};
        11: w = {OP_REGIMM, w[25:21], RI_BGEZ, w[15:0]};
        12: w = {OP_SPECIAL, w[25:6], FN_SLL};
        13: w = {OP_SPECIAL, w[25:6], FN_SRL};
        14: w = {OP_SPECIAL, w[25:6], FN_SRA};
        15: w = {OP_SPECIAL, w[25:6], FN_ADD};
        16: w = {OP_SPECIAL, w[25:6], FN_ADDU};
        17: w = {OP_SPECIAL, w[25:6], FN_SUB};
        18: w = {OP_SPECIAL, w[25:6], FN_SUBU};
        19: w = {OP_SPECIAL, w[25:6], FN_AND};
        20: w = {OP_SPECIAL, w[25:6], FN_OR};
        21: w = {OP_SPECIAL, w[25:6], FN_XOR};
        22: w = {OP_SPECIAL, w[25:6], FN_NOR};
        23: w = {OP_SPECIAL, w[25:6], FN_SLT};
        default: w = {OP_SPECIAL, w[25:6], FN_SLTU};
      endcase
    end else if (pick < 93) begin
      case ($urandom_range(0, 3))
        0: w[31:26] = OP_SPECIAL;
        1: w[31:26] = OP_REGIMM;
        2: w = '0;
        default: ;
      endcase
    end
    if (w[31:26] == OP_SPECIAL && w[5:0] == FN_BREAK) w[1] = 1'b1;
    return w;
  endfunction

  task automatic drive_requests(input bit with_gaps);
    int burst;
    burst = $urandom_range(1, 16);
    while (word_q.size() != 0) begin
      in_ch.valid            <= 1'b1;
      in_ch.instruction_word <= word_q.pop_front();
      do @(posedge clk); while (!in_ch.ready);
      burst--;
      if (with_gaps && burst == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst = $urandom_range(1, 16);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one APB transfer; a read is checked against the tracked start address
  task automatic cfg_access(input bit wr, input logic [WordW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CfgStartAddr;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      book.load_start(v);
    end else if (prdata !== book.start_addr) begin
      $display("%0t: start_address read expected %h actual %h", $time,
               book.start_addr, prdata);
      book.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_start(input logic [WordW-1:0] v);
    cfg_access(1'b1, v);
    cfg_access(1'b0, '0);
  endtask

  initial begin
    logic [WordW-1:0] start_val;
    book                   = new();
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    in_ch.valid            = 1'b0;
    in_ch.instruction_word = '0;
    out_ch.ready           = 1'b0;
    cycle_count            = 0;
    stall_mode             = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_access(1'b0, '0);
    // directed: field extremes, every group, invalid forms, NOP vs SLL
    word_q.push_back(32'h0000_0000);
    word_q.push_back({OP_SW, 5'd31, 5'd0, 16'h8000});
    word_q.push_back({OP_LW, 5'd0, 5'd31, 16'h7FFF});
    word_q.push_back({OP_J, 26'h3FF_FFFF});
    word_q.push_back({OP_J, 26'h000_0001});
    word_q.push_back({OP_BEQ, 5'd1, 5'd2, 16'h8000});
    word_q.push_back({OP_BNE, 5'd31, 5'd31, 16'hFFFF});
    word_q.push_back({OP_BGTZ, 5'd7, 5'd0, 16'h7FFF});
    word_q.push_back({OP_BLEZ, 5'd8, 5'd0, 16'h0001});
    word_q.push_back({OP_REGIMM, 5'd9, RI_BLTZ, 16'hFFFE});
    word_q.push_back({OP_REGIMM, 5'd10, RI_BGEZ, 16'h8001});
    word_q.push_back({OP_REGIMM, 5'd11, 5'd2, 16'h1234});
    word_q.push_back({OP_ADDI, 5'd3, 5'd4, 16'hFFFF});
    word_q.push_back({OP_ADDIU, 5'd31, 5'd0, 16'h8000});
    word_q.push_back({OP_SLTI, 5'd5, 5'd6, 16'h7FFF});
    word_q.push_back({OP_SPECIAL, 5'd0, 5'd31, 5'd31, 5'd31, FN_SLL});
    word_q.push_back({OP_SPECIAL, 5'd1, 5'd0, 5'd0, 5'd0, FN_SLL});
    word_q.push_back({OP_SPECIAL, 5'd0, 5'd2, 5'd3, 5'd1, FN_SRL});
    word_q.push_back({OP_SPECIAL, 5'd0, 5'd4, 5'd5, 5'd16, FN_SRA});
    word_q.push_back({OP_SPECIAL, 5'd31, 5'd31, 5'd31, 5'd0, FN_ADD});
    word_q.push_back({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_NOR});
    word_q.push_back({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, 6'h01});
    word_q.push_back(32'hFFFF_FFFF);
    word_q.push_back({6'h03, 26'h0});
    drive_requests(1'b1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: start_val = '0;
        1: start_val = 32'hFFFF_FFF0;
        2: start_val = 32'hFFFF_FFFF;
        default: start_val = $urandom();
      endcase
      write_start(start_val);
      repeat (255) word_q.push_back(random_word());
      drive_requests(ph != 1);
      wait_drained();
    end

    // BREAK switches to data mode for good; a start address write must not leave it
    word_q.push_back({OP_SPECIAL, 20'hABCDE, FN_BREAK});
    word_q.push_back({OP_SPECIAL, 20'h00000, FN_BREAK});
    word_q.push_back(32'h0000_0000);
    repeat (25) word_q.push_back($urandom());
    drive_requests(1'b1);
    wait_drained();
    write_start(32'hFFFF_FFF8);
    word_q.push_back(32'hFFFF_FFFF);
    repeat (25) word_q.push_back($urandom());
    drive_requests(1'b1);
    wait_drained();

    repeat (8) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mid_pkg.sv
src/mid_if.sv
src/mid_decode.sv
src/mid_state.sv
src/mips_instruction_decoder_core.sv
tb/tb_mips_instruction_decoder_core.sv
